FILE: src/pip_pkg.sv
// Package for the point-in-polygon test: widths, edge classes and location codes.
`default_nettype none
package pip_pkg;

	localparam int COORD_BITS = 32;
	localparam int IN_W       = 32;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	typedef enum logic [1:0] {
		EC_NONE,
		EC_TOGGLE,
		EC_BOUNDARY,
		EC_CROSS
	} edge_class_t;

	typedef enum logic [1:0] {
		LOC_OUTSIDE  = 2'd0,
		LOC_INSIDE   = 2'd1,
		LOC_BOUNDARY = 2'd2
	} location_t;

	localparam logic [1:0] CNT_FULL = 2'd3;

endpackage
`default_nettype wire

FILE: src/pip_if.sv
// Vertex and result channel interfaces of the point-in-polygon test.
`default_nettype none
interface pip_vertex_if;
	logic                         valid;
	logic                         ready;
	logic signed [pip_pkg::IN_W-1:0] vertex_x;
	logic signed [pip_pkg::IN_W-1:0] vertex_y;
	logic signed [pip_pkg::IN_W-1:0] point_x;
	logic signed [pip_pkg::IN_W-1:0] point_y;
	logic                         is_last;

	modport source (output valid, vertex_x, vertex_y, point_x, point_y, is_last, input ready);
	modport sink (input valid, vertex_x, vertex_y, point_x, point_y, is_last, output ready);
endinterface

interface pip_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] location;

	modport source (output valid, location, input ready);
	modport sink (input valid, location, output ready);
endinterface
`default_nettype wire

FILE: src/point_in_polygon_test.sv
// Streaming point-in-polygon test: one vertex item per cycle, one result per polygon.
// The polygon's last vertex passes in order through the difference register, the product
// register and the result register, which then holds the polygon's result.
// Throughput: one vertex item per cycle; the whole pipeline holds only while a result waits.
// Reset clears the vertex count, crossing parity, boundary flag and all stage valids;
// coordinate and product registers are not reset.
`default_nettype none
module point_in_polygon_test (
	input  wire              clk,
	input  wire              arst_n,
	pip_vertex_if.sink       vertex,
	pip_result_if.source     result
);

	function automatic pip_pkg::edge_class_t classify(
		input pip_pkg::diff_t dax,
		input pip_pkg::diff_t day,
		input pip_pkg::diff_t dbx,
		input pip_pkg::diff_t dby
	);
		logic bx_gt;
		logic ax_lt;
		pip_pkg::edge_class_t cls;
		bx_gt = !dbx[pip_pkg::DIFF_W-1] && (dbx != '0);
		ax_lt = dax[pip_pkg::DIFF_W-1];
		if ((dby == '0) && ((dbx == '0) || ((day == '0) && (bx_gt == ax_lt)))) begin
			cls = pip_pkg::EC_BOUNDARY;
		end else if (day[pip_pkg::DIFF_W-1] == dby[pip_pkg::DIFF_W-1]) begin
			cls = pip_pkg::EC_NONE;
		end else if (!ax_lt && bx_gt) begin
			cls = pip_pkg::EC_TOGGLE;
		end else if (ax_lt && !bx_gt) begin
			cls = pip_pkg::EC_NONE;
		end else begin
			cls = pip_pkg::EC_CROSS;
		end
		return cls;
	endfunction

	// accept side
	logic                 adv;
	logic                 acc;
	logic [1:0]           count_q;
	pip_pkg::coord_t      qx_q, qy_q, fx_q, fy_q, px_q, py_q;
	pip_pkg::coord_t      cx, cy, qx_in, qy_in, fx_in, fy_in;
	logic                 first_item;

	// stage 1: differences
	logic                 valid_s1, last_s1, e1_s1, e2_s1;
	pip_pkg::diff_t       dpx_s1, dpy_s1, dcx_s1, dcy_s1, dfx_s1, dfy_s1;

	// stage 2: products and edge classes
	logic                 valid_s2, last_s2, short_s2;
	pip_pkg::edge_class_t cls1_s2, cls2_s2;
	logic                 up1_s2, up2_s2;
	pip_pkg::prod_t       p1a_s2, p1b_s2, p2a_s2, p2b_s2;
	pip_pkg::edge_class_t cls1, cls2;

	// running polygon state and result
	logic                 parity_q, bnd_q;
	logic                 eq1, gt1, eq2, gt2;
	logic                 bnd1, tog1, bnd2, tog2;
	logic                 bnd_mid, par_mid, bnd_end, par_end;
	logic                 out_valid_q;
	logic [1:0]           location_q;

	assign adv          = !out_valid_q || result.ready;
	assign vertex.ready = adv;
	assign acc          = vertex.valid && adv;

	assign cx         = vertex.vertex_x[pip_pkg::COORD_BITS-1:0];
	assign cy         = vertex.vertex_y[pip_pkg::COORD_BITS-1:0];
	assign first_item = (count_q == 2'd0);
	assign qx_in      = first_item ? pip_pkg::coord_t'(vertex.point_x[pip_pkg::COORD_BITS-1:0]) : qx_q;
	assign qy_in      = first_item ? pip_pkg::coord_t'(vertex.point_y[pip_pkg::COORD_BITS-1:0]) : qy_q;
	assign fx_in      = first_item ? cx : fx_q;
	assign fy_in      = first_item ? cy : fy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (acc) begin
			if (vertex.is_last) begin
				count_q <= 2'd0;
			end else if (count_q != pip_pkg::CNT_FULL) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			qx_q <= qx_in;
			qy_q <= qy_in;
			fx_q <= fx_in;
			fy_q <= fy_in;
			px_q <= cx;
			py_q <= cy;
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= vertex.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			last_s1 <= vertex.is_last;
			e1_s1   <= !first_item;
			// closing edge only once the polygon has three vertices
			e2_s1   <= vertex.is_last && count_q[1];
			dpx_s1  <= pip_pkg::diff_t'(px_q) - pip_pkg::diff_t'(qx_in);
			dpy_s1  <= pip_pkg::diff_t'(py_q) - pip_pkg::diff_t'(qy_in);
			dcx_s1  <= pip_pkg::diff_t'(cx) - pip_pkg::diff_t'(qx_in);
			dcy_s1  <= pip_pkg::diff_t'(cy) - pip_pkg::diff_t'(qy_in);
			dfx_s1  <= pip_pkg::diff_t'(fx_in) - pip_pkg::diff_t'(qx_in);
			dfy_s1  <= pip_pkg::diff_t'(fy_in) - pip_pkg::diff_t'(qy_in);
		end
	end

	// stage 2
	assign cls1 = e1_s1 ? classify(dpx_s1, dpy_s1, dcx_s1, dcy_s1) : pip_pkg::EC_NONE;
	assign cls2 = e2_s1 ? classify(dcx_s1, dcy_s1, dfx_s1, dfy_s1) : pip_pkg::EC_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			last_s2  <= last_s1;
			short_s2 <= !e2_s1;
			cls1_s2  <= cls1;
			cls2_s2  <= cls2;
			up1_s2   <= dpy_s1[pip_pkg::DIFF_W-1];
			up2_s2   <= dcy_s1[pip_pkg::DIFF_W-1];
			p1a_s2   <= pip_pkg::prod_t'(dpx_s1) * pip_pkg::prod_t'(dcy_s1);
			p1b_s2   <= pip_pkg::prod_t'(dcx_s1) * pip_pkg::prod_t'(dpy_s1);
			p2a_s2   <= pip_pkg::prod_t'(dcx_s1) * pip_pkg::prod_t'(dfy_s1);
			p2b_s2   <= pip_pkg::prod_t'(dfx_s1) * pip_pkg::prod_t'(dcy_s1);
		end
	end

	// sign of the cross product, then fold both edges into the running state in order
	assign eq1  = (p1a_s2 == p1b_s2);
	assign gt1  = (p1a_s2 > p1b_s2);
	assign eq2  = (p2a_s2 == p2b_s2);
	assign gt2  = (p2a_s2 > p2b_s2);
	assign bnd1 = (cls1_s2 == pip_pkg::EC_BOUNDARY) || ((cls1_s2 == pip_pkg::EC_CROSS) && eq1);
	assign tog1 = (cls1_s2 == pip_pkg::EC_TOGGLE)
		|| ((cls1_s2 == pip_pkg::EC_CROSS) && !eq1 && (gt1 == up1_s2));
	assign bnd2 = (cls2_s2 == pip_pkg::EC_BOUNDARY) || ((cls2_s2 == pip_pkg::EC_CROSS) && eq2);
	assign tog2 = (cls2_s2 == pip_pkg::EC_TOGGLE)
		|| ((cls2_s2 == pip_pkg::EC_CROSS) && !eq2 && (gt2 == up2_s2));

	assign bnd_mid = bnd_q || bnd1;
	assign par_mid = parity_q ^ (!bnd_q && tog1);
	assign bnd_end = bnd_mid || bnd2;
	assign par_end = par_mid ^ (!bnd_mid && tog2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			bnd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2 && last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					parity_q <= 1'b0;
					bnd_q    <= 1'b0;
				end else begin
					parity_q <= par_end;
					bnd_q    <= bnd_end;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && last_s2) begin
			if (short_s2) begin
				location_q <= pip_pkg::LOC_OUTSIDE;
			end else if (bnd_end) begin
				location_q <= pip_pkg::LOC_BOUNDARY;
			end else if (par_end) begin
				location_q <= pip_pkg::LOC_INSIDE;
			end else begin
				location_q <= pip_pkg::LOC_OUTSIDE;
			end
		end
	end

	assign result.valid    = out_valid_q;
	assign result.location = location_q;

endmodule
`default_nettype wire
